[hw/rtl/eafr_pkg.sv]
// Shared types and constants for the Euler angle extraction pipeline.
package eafr_pkg;

   localparam int MAX_STEPS = 24;
   localparam int ANG_W = 27;
   localparam int VEC_W = 34;
   localparam int CFG_W = 15;
   localparam logic signed [ANG_W-1:0] DEG180_Z = 27'sd11796480;
   localparam logic signed [15:0] DEG90_OUT = 16'sd11520;
   localparam logic signed [ANG_W-1:0] OUT_LIMIT = 27'sd23040;
   localparam logic signed [16:0] ONE_Q14 = 17'sd16384;

   typedef enum logic [1:0] {
      LOCK_NONE = 2'd0,
      LOCK_POS = 2'd1,
      LOCK_NEG = 2'd2
   } lock_type;

   function automatic logic signed [ANG_W-1:0] atan_deg16(input int idx);
      logic signed [ANG_W-1:0] r;
      case (idx)
         0: r = 27'sd2949120;
         1: r = 27'sd1740967;
         2: r = 27'sd919879;
         3: r = 27'sd466945;
         4: r = 27'sd234379;
         5: r = 27'sd117304;
         6: r = 27'sd58666;
         7: r = 27'sd29335;
         8: r = 27'sd14668;
         9: r = 27'sd7334;
         10: r = 27'sd3667;
         11: r = 27'sd1833;
         12: r = 27'sd917;
         13: r = 27'sd458;
         14: r = 27'sd229;
         15: r = 27'sd115;
         16: r = 27'sd57;
         17: r = 27'sd29;
         18: r = 27'sd14;
         19: r = 27'sd7;
         20: r = 27'sd4;
         21: r = 27'sd2;
         22: r = 27'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

[hw/rtl/eafr_isqrt.sv]
// Pipelined integer square root, one root bit per stage.
module eafr_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [28:0] in_radicand,
   output logic        out_valid,
   output logic [14:0] out_root
);

   localparam int STAGES = 15;

   logic [28:0] rem_ff [0:STAGES];
   logic [28:0] root_ff [0:STAGES];
   logic [STAGES:0] valid_ff;

   always_ff @(posedge clock) begin
      rem_ff[0] <= in_radicand;
      root_ff[0] <= '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[STAGES-1:0], in_valid};
      end
   end

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      localparam logic [28:0] BIT = 29'd1 << (2 * (STAGES - 1 - s));
      logic [28:0] rem_in;
      logic [28:0] root_in;
      always_comb begin
         if (rem_ff[s] >= root_ff[s] + BIT) begin
            rem_in = rem_ff[s] - (root_ff[s] + BIT);
            root_in = (root_ff[s] >> 1) + BIT;
         end else begin
            rem_in = rem_ff[s];
            root_in = root_ff[s] >> 1;
         end
      end
      always_ff @(posedge clock) begin
         rem_ff[s+1] <= rem_in;
         root_ff[s+1] <= root_in;
      end
   end

   assign out_valid = valid_ff[STAGES];
   assign out_root = root_ff[STAGES][14:0];

endmodule

[hw/rtl/eafr_cordic.sv]
// Pipelined vectoring CORDIC giving atan2 in degrees with 7 fraction bits.
module eafr_cordic #(
   parameter int STEPS = 16,
   parameter int DELAY = 0
) (
   input  logic               clock,
   input  logic signed [16:0] in_y,
   input  logic signed [16:0] in_x,
   output logic signed [15:0] out_angle
);

   localparam int N = (STEPS > eafr_pkg::MAX_STEPS) ? eafr_pkg::MAX_STEPS : STEPS;
   localparam int VW = eafr_pkg::VEC_W;
   localparam int AW = eafr_pkg::ANG_W;

   logic signed [VW-1:0] x_ff [0:N];
   logic signed [VW-1:0] y_ff [0:N];
   logic signed [AW-1:0] z_ff [0:N];
   logic zero_ff [0:N];
   logic signed [AW-1:0] dly_ff [0:DELAY];
   logic signed [15:0] res_ff;

   logic signed [VW-1:0] x0_in, y0_in;
   logic signed [AW-1:0] z0_in;

   always_comb begin
      x0_in = VW'(in_x) <<< 14;
      y0_in = VW'(in_y) <<< 14;
      z0_in = '0;
      if (in_x < 0) begin
         z0_in = (in_y >= 0) ? eafr_pkg::DEG180_Z : -eafr_pkg::DEG180_Z;
         x0_in = -x0_in;
         y0_in = -y0_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff[0] <= x0_in;
      y_ff[0] <= y0_in;
      z_ff[0] <= z0_in;
      zero_ff[0] <= (in_x == 0) && (in_y == 0);
   end

   for (genvar i = 0; i < N; i++) begin : g_step
      always_ff @(posedge clock) begin
         zero_ff[i+1] <= zero_ff[i];
         if (y_ff[i] >= 0) begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + eafr_pkg::atan_deg16(i);
         end else begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - eafr_pkg::atan_deg16(i);
         end
      end
   end

   logic signed [AW-1:0] rnd_in;
   always_comb begin
      rnd_in = (z_ff[N] + $signed(AW'(256))) >>> 9;
      if (zero_ff[N]) rnd_in = '0;
      else if (rnd_in > eafr_pkg::OUT_LIMIT) rnd_in = eafr_pkg::OUT_LIMIT;
      else if (rnd_in < -eafr_pkg::OUT_LIMIT) rnd_in = -eafr_pkg::OUT_LIMIT;
   end

   always_ff @(posedge clock) begin
      dly_ff[0] <= rnd_in;
   end
   for (genvar d = 0; d < DELAY; d++) begin : g_dly
      always_ff @(posedge clock) dly_ff[d+1] <= dly_ff[d];
   end
   always_ff @(posedge clock) res_ff <= dly_ff[DELAY][15:0];

   assign out_angle = res_ff;

endmodule

[hw/rtl/euler_angles_from_rotation.sv]
// Top level: Euler angles (Y*X*Z convention) from a Q1.14 rotation matrix.
// One matrix transfer is taken every cycle; busy stays low outside reset.
// The pipeline depth is set by the 15-stage square root ahead of the asin
// CORDIC; the other CORDICs are delayed to match. Each result is
// shown for exactly one cycle with rsp_valid high and cannot be held off.
module euler_angles_from_rotation #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic signed [15:0] req_elem_r1c1,
   input  logic signed [15:0] req_elem_r1c2,
   input  logic signed [15:0] req_elem_r1c3,
   input  logic signed [15:0] req_elem_r2c1,
   input  logic signed [15:0] req_elem_r2c2,
   input  logic signed [15:0] req_elem_r2c3,
   input  logic signed [15:0] req_elem_r3c3,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [14:0] csr_gimbal_threshold,
   output logic        rsp_valid,
   output logic signed [15:0] rsp_angle_x_deg,
   output logic signed [15:0] rsp_angle_y_deg,
   output logic signed [15:0] rsp_angle_z_deg,
   output logic [1:0]  rsp_lock_case
);

   localparam int N = (CORDIC_STEPS > eafr_pkg::MAX_STEPS) ?
                      eafr_pkg::MAX_STEPS : CORDIC_STEPS;
   localparam int SQ = 15;
   localparam int LAT = SQ + N + 6;

   logic [eafr_pkg::CFG_W-1:0] thr_ff;
   logic accept;

   assign busy = reset;
   assign csr_ready = 1'b1;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= 15'd16;
      end else if (csr_valid && csr_ready) begin
         thr_ff <= csr_gimbal_threshold;
      end
   end

   // Stage 1: lock test, clamp, operand prep.
   logic signed [16:0] s_in, s_ff;
   logic signed [17:0] dp, dm;
   logic [17:0] adp, adm;
   eafr_pkg::lock_type lock_in, lock_ff;
   logic signed [16:0] zy_ff, zx_ff, yy_ff, yx_ff;
   logic v1_ff;

   always_comb begin
      dp = 18'(req_elem_r2c3) - 18'sd16384;
      dm = 18'(req_elem_r2c3) + 18'sd16384;
      adp = dp < 0 ? 18'(-dp) : 18'(dp);
      adm = dm < 0 ? 18'(-dm) : 18'(dm);
      if (adp < 18'(thr_ff)) lock_in = eafr_pkg::LOCK_POS;
      else if (adm < 18'(thr_ff)) lock_in = eafr_pkg::LOCK_NEG;
      else lock_in = eafr_pkg::LOCK_NONE;
      s_in = 17'(req_elem_r2c3);
      if (s_in > eafr_pkg::ONE_Q14) s_in = eafr_pkg::ONE_Q14;
      if (s_in < -eafr_pkg::ONE_Q14) s_in = -eafr_pkg::ONE_Q14;
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= accept;
      lock_ff <= lock_in;
      s_ff <= s_in;
      if (lock_in == eafr_pkg::LOCK_NONE) begin
         zy_ff <= -17'(req_elem_r2c1);
         zx_ff <= 17'(req_elem_r2c2);
      end else begin
         zy_ff <= 17'(req_elem_r1c2);
         zx_ff <= 17'(req_elem_r1c1);
      end
      yy_ff <= -17'(req_elem_r1c3);
      yx_ff <= 17'(req_elem_r3c3);
   end

   // Stage 2: radicand of one minus the squared pitch sine.
   logic [28:0] rad_ff;
   logic signed [16:0] s2_ff;
   logic v2_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else v2_ff <= v1_ff;
      rad_ff <= 29'(29'd268435456 - 29'(34'(s_ff * s_ff)));
      s2_ff <= s_ff;
   end

   logic sq_valid;
   logic [14:0] sq_root;
   eafr_isqrt u_isqrt (
      .clock(clock), .reset(reset), .in_valid(v2_ff),
      .in_radicand(rad_ff), .out_valid(sq_valid), .out_root(sq_root)
   );

   logic signed [16:0] s_dly_ff [0:SQ];
   always_ff @(posedge clock) begin
      s_dly_ff[0] <= s2_ff;
      for (int k = 1; k <= SQ; k++) s_dly_ff[k] <= s_dly_ff[k-1];
   end

   logic signed [15:0] ax_ang, ay_ang, az_ang;
   eafr_cordic #(.STEPS(CORDIC_STEPS), .DELAY(0)) u_asin (
      .clock(clock), .in_y(s_dly_ff[SQ]), .in_x(17'({2'b00, sq_root})),
      .out_angle(ax_ang)
   );
   eafr_cordic #(.STEPS(CORDIC_STEPS), .DELAY(SQ + 2)) u_aty (
      .clock(clock), .in_y(yy_ff), .in_x(yx_ff), .out_angle(ay_ang)
   );
   eafr_cordic #(.STEPS(CORDIC_STEPS), .DELAY(SQ + 2)) u_atz (
      .clock(clock), .in_y(zy_ff), .in_x(zx_ff), .out_angle(az_ang)
   );

   logic [LAT-2:0] v_dly_ff;
   eafr_pkg::lock_type lk_dly_ff [0:LAT-2];
   always_ff @(posedge clock) begin
      if (reset) v_dly_ff <= '0;
      else v_dly_ff <= {v_dly_ff[LAT-3:0], v1_ff};
      lk_dly_ff[0] <= lock_ff;
      for (int k = 1; k < LAT - 1; k++) lk_dly_ff[k] <= lk_dly_ff[k-1];
   end

   eafr_pkg::lock_type lk_out;
   assign lk_out = lk_dly_ff[LAT-2];
   assign rsp_valid = v_dly_ff[LAT-2] & ~sq_valid | v_dly_ff[LAT-2];
   assign rsp_lock_case = lk_out;
   assign rsp_angle_x_deg = (lk_out == eafr_pkg::LOCK_POS) ? eafr_pkg::DEG90_OUT :
                            (lk_out == eafr_pkg::LOCK_NEG) ? -eafr_pkg::DEG90_OUT : ax_ang;
   assign rsp_angle_y_deg = (lk_out == eafr_pkg::LOCK_NONE) ? ay_ang : '0;
   assign rsp_angle_z_deg = az_ang;

endmodule

[tb/sv/euler_angles_from_rotation_test.sv]
// Self-checking testbench for the Euler angle extraction pipeline.
`timescale 1ns / 100ps

module euler_angles_from_rotation_test;

   localparam int STEPS = 16;
   localparam int LATENCY = STEPS + 21;
   localparam int N_RANDOM = 1150;

   typedef struct {
      logic signed [15:0] r11, r12, r13, r21, r22, r23, r33;
   } matrix_type;

   typedef struct {
      logic signed [15:0] ax, ay, az;
      eafr_pkg::lock_type lock;
   } angles_type;

   typedef struct {
      matrix_type m;
      bit      typed;
      angles_type a;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [15:0] req_elem_r1c1 = '0, req_elem_r1c2 = '0, req_elem_r1c3 = '0;
   logic signed [15:0] req_elem_r2c1 = '0, req_elem_r2c2 = '0, req_elem_r2c3 = '0;
   logic signed [15:0] req_elem_r3c3 = '0;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [14:0] csr_gimbal_threshold = '0;
   logic rsp_valid;
   logic signed [15:0] rsp_angle_x_deg, rsp_angle_y_deg, rsp_angle_z_deg;
   logic [1:0] rsp_lock_case;

   euler_angles_from_rotation #(.CORDIC_STEPS(STEPS)) uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #50ms;
      $display("Mismatches found");
      $finish;
   end

   logic [14:0] lock_margin;
   angles_type pending_angles[$];
   int mismatch_count = 0;

   function automatic longint floor_shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic logic signed [15:0] cordic_atan2(longint y, longint x);
      longint z, xs, ys;
      z = 0;
      if (x == 0 && y == 0) return '0;
      if (x < 0) begin
         z = (y >= 0) ? 11796480 : -11796480;
         x = -x;
         y = -y;
      end
      x = x * 16384;
      y = y * 16384;
      for (int i = 0; i < ((STEPS > 24) ? 24 : STEPS); i++) begin
         xs = floor_shr(x, i);
         ys = floor_shr(y, i);
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z += longint'(eafr_pkg::atan_deg16(i));
         end else begin
            x = x - ys;
            y = y + xs;
            z -= longint'(eafr_pkg::atan_deg16(i));
         end
      end
      z = floor_shr(z + 256, 9);
      if (z > 23040) z = 23040;
      if (z < -23040) z = -23040;
      return z[15:0];
   endfunction

   function automatic longint int_sqrt(longint n);
      longint root, b;
      root = 0;
      b = longint'(1) << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= root + b) begin
            n -= root + b;
            root = (root >> 1) + b;
         end else begin
            root >>= 1;
         end
         b >>= 2;
      end
      return root;
   endfunction

   function automatic angles_type predict_angles(matrix_type m);
      angles_type a;
      longint s, dp, dm;
      s = m.r23;
      dp = s - 16384;
      dm = s + 16384;
      if (dp < 0) dp = -dp;
      if (dm < 0) dm = -dm;
      if (dp < longint'(lock_margin)) begin
         a.ax = eafr_pkg::DEG90_OUT;
         a.ay = '0;
         a.az = cordic_atan2(m.r12, m.r11);
         a.lock = eafr_pkg::LOCK_POS;
      end else if (dm < longint'(lock_margin)) begin
         a.ax = -eafr_pkg::DEG90_OUT;
         a.ay = '0;
         a.az = cordic_atan2(m.r12, m.r11);
         a.lock = eafr_pkg::LOCK_NEG;
      end else begin
         if (s > 16384) s = 16384;
         if (s < -16384) s = -16384;
         a.ax = cordic_atan2(s, int_sqrt((longint'(1) << 28) - s * s));
         a.ay = cordic_atan2(-longint'(m.r13), m.r33);
         a.az = cordic_atan2(-longint'(m.r21), m.r22);
         a.lock = eafr_pkg::LOCK_NONE;
      end
      return a;
   endfunction

   always @(posedge clock) begin
      angles_type e;
      if (!reset && rsp_valid) begin
         if (pending_angles.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected result x=%0d y=%0d z=%0d lock=%0d", rsp_angle_x_deg,
                        rsp_angle_y_deg, rsp_angle_z_deg, rsp_lock_case);
         end else begin
            e = pending_angles.pop_front();
            if (rsp_angle_x_deg !== e.ax || rsp_angle_y_deg !== e.ay ||
                rsp_angle_z_deg !== e.az || rsp_lock_case !== e.lock) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Result mismatch: expected x=%0d y=%0d z=%0d lock=%0d, got %0d %0d %0d %0d",
                           e.ax, e.ay, e.az, e.lock, rsp_angle_x_deg, rsp_angle_y_deg,
                           rsp_angle_z_deg, rsp_lock_case);
            end
         end
      end
   end

   task automatic write_margin(logic [14:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_gimbal_threshold <= value;
      do @(posedge clock); while (!csr_ready);
      lock_margin = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain;
      while (pending_angles.size() != 0) @(posedge clock);
   endtask

   // One matrix transfer; the caller is at a falling edge.
   task automatic send_matrix(matrix_type m, bit typed, angles_type a);
      angles_type e;
      e = typed ? a : predict_angles(m);
      start <= 1'b1;
      req_elem_r1c1 <= m.r11;
      req_elem_r1c2 <= m.r12;
      req_elem_r1c3 <= m.r13;
      req_elem_r2c1 <= m.r21;
      req_elem_r2c2 <= m.r22;
      req_elem_r2c3 <= m.r23;
      req_elem_r3c3 <= m.r33;
      do @(posedge clock); while (busy);
      pending_angles.push_back(e);
      @(negedge clock);
   endtask

   function automatic logic signed [15:0] rand_elem();
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'($urandom_range(0, 16384));
         3: return 16'(-$signed(17'($urandom_range(0, 16384))));
         default: return 16'($urandom);
      endcase
   endfunction

   // Random matrices with independent elements; r2c3 is steered toward the lock edges often.
   function automatic matrix_type rand_matrix();
      matrix_type m;
      int d;
      m.r11 = rand_elem();
      m.r12 = rand_elem();
      m.r13 = rand_elem();
      m.r21 = rand_elem();
      m.r22 = rand_elem();
      m.r33 = rand_elem();
      d = $urandom_range(0, 40);
      case ($urandom_range(0, 3))
         0: m.r23 = 16'(16384 - d + 20);
         1: m.r23 = 16'(-16384 + d - 20);
         default: m.r23 = rand_elem();
      endcase
      return m;
   endfunction

   stim_row_type directed[$];
   logic [14:0] margins[5] = '{15'd16, 15'd0, 15'd16384, 15'd32767, 15'd300};

   function automatic stim_row_type row(int r11, int r12, int r13, int r21, int r22, int r23,
                                        int r33, bit typed = 0, int ax = 0, int ay = 0,
                                        int az = 0,
                                        eafr_pkg::lock_type lk = eafr_pkg::LOCK_NONE);
      stim_row_type r;
      r.m = '{16'(r11), 16'(r12), 16'(r13), 16'(r21), 16'(r22), 16'(r23), 16'(r33)};
      r.typed = typed;
      r.a = '{16'(ax), 16'(ay), 16'(az), lk};
      return r;
   endfunction

   initial begin
      angles_type none;
      int gap;
      none = '{'0, '0, '0, eafr_pkg::LOCK_NONE};
      directed = '{
         row(16384, 0, 0, 0, 16384, 0, 16384, 1, 0, 0, 0, eafr_pkg::LOCK_NONE),
         row(0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, eafr_pkg::LOCK_NONE),
         row(0, 0, 0, 0, 0, 16384, 0, 1, 11520, 0, 0, eafr_pkg::LOCK_POS),
         row(0, 0, 0, 0, 0, -16384, 0, 1, -11520, 0, 0, eafr_pkg::LOCK_NEG),
         row(0, 0, 0, 0, 0, 16368, 0),
         row(0, 0, 0, 0, 0, 16369, 0),
         row(0, 0, 0, 0, 0, -16369, 0),
         row(0, 0, 0, 0, 0, -16368, 0),
         row(0, 0, 0, 0, 0, 32767, 0),
         row(0, 0, 0, 0, 0, -32768, 0),
         row(-16384, 0, 0, 0, -16384, 0, -16384),
         row(-16384, -1, 1, 1, -16384, 0, -16384),
         row(-32768, -32768, -32768, -32768, -32768, 0, -32768),
         row(32767, 32767, 32767, 32767, 32767, 0, 32767),
         row(-32768, 32767, 32767, -32768, -32768, 16384, 32767),
         row(0, -32768, 32767, 32767, 0, 11585, 0),
         row(11585, 11585, -11585, 11585, 11585, -11585, -11585),
         row(1, 0, 0, 0, 1, 8192, 1),
         row(0, 1, -1, -1, 0, -8192, 0)
      };
      lock_margin = 15'd16;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send_matrix(directed[i].m, directed[i].typed, directed[i].a);
      start <= 1'b0;
      for (int ph = 0; ph < 5; ph++) begin
         drain();
         repeat (LATENCY + 4) @(posedge clock);
         write_margin(margins[ph]);
         for (int k = 0; k < N_RANDOM / 5; k++) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
            if (ph >= 3) gap = 0;
            if (gap != 0) begin
               start <= 1'b0;
               repeat (gap) @(negedge clock);
            end
            if (k == 100) begin
               start <= 1'b0;
               drain();
               @(negedge clock);
            end
            send_matrix(rand_matrix(), 1'b0, none);
         end
         start <= 1'b0;
      end
      drain();
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatch_count == 0 && pending_angles.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
